### rtl/core/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduce unit.
package rar_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic mul1;      // first product pair
    logic mul2;      // product of the two denominators
    logic combine;   // form magnitude and denominator
    logic gcd_step;  // one subtract-shift step of binary gcd
    logic div_init;  // start quotient division
    logic div_step;  // one restoring division bit
    logic finish;    // form result word
  } rar_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mag_zero;
    logic gcd_done;
    logic div_done;
  } rar_stat_t;

endpackage

### rtl/core/rar_ctrl.sv
// Controller state machine for the rational arithmetic reduce unit.
module rar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rar_pkg::rar_cmd_t cmd,
  input  rar_pkg::rar_stat_t stat
);
  import rar_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DINIT, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mul1     = (state == S_MUL1);
    cmd.mul2     = (state == S_MUL2);
    cmd.combine  = (state == S_COMB);
    cmd.gcd_step = (state == S_GCD);
    cmd.div_init = (state == S_DINIT);
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_COMB;
        S_COMB:  state <= S_GCD;
        S_GCD: begin
          if (stat.mag_zero) state <= S_FIN;
          else if (stat.gcd_done) state <= S_DINIT;
        end
        S_DINIT: state <= S_DIV;
        S_DIV:   if (stat.div_done) state <= S_FIN;
        S_FIN:   state <= S_OUT;
        S_OUT:   if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/rar_dp.sv
// Datapath: cross products, binary gcd and serial division by the gcd.
module rar_dp #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  rar_pkg::rar_cmd_t               cmd,
  output rar_pkg::rar_stat_t              stat,
  input  logic [1:0]                      command,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic [OPERAND_WIDTH-1:0]        a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic [OPERAND_WIDTH-1:0]        b_den,
  output logic signed [2*OPERAND_WIDTH:0] res_num,
  output logic [2*OPERAND_WIDTH-1:0]      res_den,
  output logic                            div_zero
);
  import rar_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = PW + 1;
  localparam int CW = $clog2(MW + 1);
  localparam int KW = $clog2(PW + 1);

  cmd_t           op;
  logic [W-1:0]   ma, mb, ad, bd;
  logic           sa, sb;
  logic [PW-1:0]  p1, p2, pd;
  logic [MW-1:0]  mag;
  logic [PW-1:0]  den;
  logic           neg, dz;
  logic [MW-1:0]  gx, gy;
  logic [KW-1:0]  k;
  logic [MW-1:0]  g;
  logic [MW-1:0]  rem, quo;
  logic [CW-1:0]  cnt;
  logic           phase;

  logic [W-1:0]   m1a, m1b, m2a, m2b;
  logic [PW-1:0]  m1, m2;
  logic           s2;
  logic [MW-1:0]  rem_sh;
  logic [MW-1:0]  gdiff;

  always_comb begin
    m1a = ma; m1b = bd; m2a = mb; m2b = ad;
    if (op == CMD_MUL) begin
      m1b = mb; m2a = ad; m2b = bd;
    end else if (op == CMD_DIV) begin
      m2a = ad; m2b = mb;
    end
  end
  assign m1 = PW'(m1a * m1b);
  assign m2 = PW'(m2a * m2b);
  assign s2 = (op == CMD_SUB) ? !sb : sb;

  // g is cleared on combine and set on the first gcd step
  assign stat.mag_zero = (mag == '0);
  assign stat.gcd_done = (g != '0) && (gy == '0);
  assign stat.div_done = phase && (cnt == '0);

  assign rem_sh  = {rem[MW-2:0], quo[MW-1]};
  assign gdiff   = (gx > gy) ? gx - gy : gy - gx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= cmd_t'(command);
      sa <= a_num[W-1];
      sb <= b_num[W-1];
      ma <= a_num[W-1] ? W'(-a_num) : W'(a_num);
      mb <= b_num[W-1] ? W'(-b_num) : W'(b_num);
      ad <= a_den;
      bd <= b_den;
    end
    if (cmd.mul1) begin
      p1 <= m1;
      p2 <= m2;
    end
    if (cmd.mul2) begin
      pd <= PW'(ad * bd);
    end
    if (cmd.combine) begin
      dz  <= 1'b0;
      den <= (op == CMD_DIV) ? p2 : pd;
      if (op == CMD_ADD || op == CMD_SUB) begin
        if (sa == s2) begin
          mag <= MW'(p1) + MW'(p2); neg <= sa;
        end else if (p1 >= p2) begin
          mag <= MW'(p1 - p2); neg <= sa;
        end else begin
          mag <= MW'(p2 - p1); neg <= s2;
        end
      end else if (op == CMD_MUL) begin
        mag <= MW'(p1); neg <= sa ^ sb;
      end else begin
        mag <= MW'(p1); neg <= sa ^ sb;
        if (mb == '0) begin
          dz <= 1'b1; neg <= sa;
        end
      end
    end
    if (cmd.gcd_step && stat.mag_zero) begin
      neg <= 1'b0;
      den <= PW'(1);
    end
    if (cmd.combine) begin
      gx <= '0; gy <= '0; k <= '0;
    end
    if (cmd.gcd_step) begin
      if (gx == '0 && gy == '0 && k == '0 && phase == 1'b0 && g == '0) begin
        gx <= mag;
        gy <= (den == '0) ? MW'(1) : MW'(den);
        g  <= MW'(1);
        if (den == '0) den <= PW'(1);
      end else if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1; gy <= gy >> 1; k <= k + KW'(1);
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else begin
        gx <= (gx < gy) ? gx : gy;
        gy <= gdiff;
      end
    end
    if (cmd.combine) g <= '0;
    if (cmd.div_init) begin
      g     <= gx << k;
      rem   <= '0;
      quo   <= mag;
      cnt   <= CW'(MW);
      phase <= 1'b0;
    end
    if (cmd.div_step) begin
      if (cnt == '0) begin
        if (!phase) begin
          mag   <= quo;
          rem   <= '0;
          quo   <= MW'(den);
          cnt   <= CW'(MW);
          phase <= 1'b1;
        end
      end else begin
        if (rem_sh >= g) begin
          rem <= rem_sh - g;
          quo <= {quo[MW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[MW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (phase && cnt == CW'(1)) begin
          den <= PW'(rem_sh >= g ? {quo[MW-2:0], 1'b1} : {quo[MW-2:0], 1'b0});
        end
      end
    end
    if (cmd.combine) phase <= 1'b0;
    if (cmd.finish) begin
      res_num  <= neg ? -$signed(mag) : $signed(mag);
      res_den  <= den;
      div_zero <= dz;
    end
  end
endmodule

### rtl/core/rational_arith_reduce_unit.sv
// Rational arithmetic reduce unit: top level.
// Steps: load, two product states, combine, gcd loop, divider init, serial division of
// magnitude and denominator by the gcd, finish and output; a zero numerator skips to finish.
// Throughput: one word at a time; next word taken once the result is delivered.
// The gcd loop and serial restoring divider take most of the time per word.
// Reset: synchronous, active high; clears the controller, datapath holds no reset.
module rational_arith_reduce_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic [OPERAND_WIDTH-1:0]        a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic [OPERAND_WIDTH-1:0]        b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [2*OPERAND_WIDTH:0] res_num,
  output logic [2*OPERAND_WIDTH-1:0]      res_den,
  output logic                            div_zero
);
  import rar_pkg::*;

  rar_cmd_t  cmd;
  rar_stat_t stat;

  rar_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  rar_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk, .cmd, .stat, .command, .a_num, .a_den, .b_num, .b_den,
    .res_num, .res_den, .div_zero
  );

`ifndef SYNTHESIS
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res_den != '0) else $error("zero denominator");
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("overlapping commands");
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !cmd.load) else $error("load while result held");
`endif
endmodule
